FILE: hdl/lpfc_pkg.sv
// Shared constants and types for the LRU page fault counter.
package lpfc_pkg;

  localparam int CAPACITY  = 16;
  localparam int PAGE_BITS = 16;
  localparam int FIELD_W   = 16;
  localparam int CFG_W     = 5;
  localparam int RANK_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W     = $clog2(CAPACITY + 1);
  localparam int CAP_W     = (OCC_W > CFG_W) ? OCC_W : CFG_W;
  localparam logic [FIELD_W-1:0] FAULT_MAX = '1;
  localparam logic [CFG_W-1:0]   CAP_RESET = CFG_W'(16);

  // Lookup outcome for one access.
  typedef struct packed {
    logic               hit;
    logic               ev_valid;
    logic [FIELD_W-1:0] ev_page;
  } lpfc_res_t;

endpackage

FILE: hdl/lpfc_frame_table.sv
// Frame table: page tags, valid bits and recency ranks with one-pass LRU update.
module lpfc_frame_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         upd,
  input  logic [lpfc_pkg::PAGE_BITS-1:0] page,
  input  logic                         clear,
  input  logic [lpfc_pkg::CAP_W-1:0]   eff_cap,
  output lpfc_pkg::lpfc_res_t          res
);

  localparam int N  = lpfc_pkg::CAPACITY;
  localparam int RW = lpfc_pkg::RANK_W;
  localparam int OW = lpfc_pkg::OCC_W;

  logic [lpfc_pkg::PAGE_BITS-1:0] page_r [N];
  logic [RW-1:0]                  rank_r [N];
  logic [RW-1:0]                  rank_nxt [N];
  logic [N-1:0]                   valid_r, valid_nxt;
  logic [OW-1:0]                  occ_r, occ_nxt;

  logic [N-1:0]  valid_e, match, victim, free_oh, slot;
  logic [OW-1:0] occ_e;
  logic [RW-1:0] hit_rank, lru_rank;
  logic          hit, full, evict;
  logic [lpfc_pkg::PAGE_BITS-1:0] ev_page;

  assign valid_e  = clear ? '0 : valid_r;
  assign occ_e    = clear ? '0 : occ_r;
  assign full     = (lpfc_pkg::CAP_W'(occ_e) >= eff_cap);
  assign lru_rank = RW'(occ_e - OW'(1));
  // lowest free frame
  assign free_oh  = ~valid_e & (~(~valid_e) + N'(1));

  always_comb begin
    for (int i = 0; i < N; i++) begin
      match[i]  = valid_e[i] && (page_r[i] == page);
      victim[i] = valid_e[i] && (rank_r[i] == lru_rank);
    end
  end

  assign hit   = |match;
  assign evict = !hit && full;
  assign slot  = evict ? victim : free_oh;

  always_comb begin
    hit_rank = '0;
    ev_page  = '0;
    for (int i = 0; i < N; i++) begin
      if (match[i]) hit_rank = hit_rank | rank_r[i];
      if (victim[i] && evict) ev_page = ev_page | page_r[i];
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      rank_nxt[i]  = rank_r[i];
      valid_nxt[i] = valid_e[i];
      if (hit) begin
        if (match[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_e[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + RW'(1);
        end
      end else begin
        if (slot[i]) begin
          rank_nxt[i]  = '0;
          valid_nxt[i] = 1'b1;
        end else if (valid_e[i]) begin
          rank_nxt[i] = rank_r[i] + RW'(1);
        end
      end
    end
    occ_nxt = (hit || evict) ? occ_e : occ_e + OW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < N; i++) rank_r[i] <= '0;
    end else if (upd) begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < N; i++) rank_r[i] <= rank_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (upd && !hit) begin
      for (int i = 0; i < N; i++) begin
        if (slot[i]) page_r[i] <= page;
      end
    end
  end

  assign res.hit      = hit;
  assign res.ev_valid = evict;
  assign res.ev_page  = lpfc_pkg::FIELD_W'(ev_page);

endmodule

FILE: hdl/lru_page_fault_counter.sv
// Top level of the LRU page fault counter: handshake, fault counter, result register.
//
// Fully associative LRU page replacement over up to 16 frames. Each accepted
// transaction carries one page reference and yields exactly one result: hit or
// fault, the evicted page if any, and the saturating fault count of the run.
// One transaction is taken every cycle while the result is not stalled. The
// input register loads at acceptance and the result register when the pass
// fires; a stalled result register holds the input register, which then
// stalls the input. The single pass of the 16-way tag compare and rank
// update sits between those two registers. No clearing pass is needed after
// reset: frame valid bits and ranks clear at once. The user must write
// capacity_in_use only while the block is idle; the block does not enforce
// it. 0 acts as 1 and values above 16 act as 16.
module lru_page_fault_counter (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_page_number,
  input  logic        in_first_of_run,
  input  logic        in_last_of_run,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic        out_evicted_valid,
  output logic [15:0] out_evicted_page,
  output logic [15:0] out_fault_count,
  output logic        out_run_done
);

  localparam int FW = lpfc_pkg::FIELD_W;
  localparam int CW = lpfc_pkg::CAP_W;

  // capacity register
  logic [lpfc_pkg::CFG_W-1:0] cap_r;
  logic [CW-1:0] cap_ext, eff_cap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lpfc_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign cap_ext = CW'(cap_r);

  always_comb begin
    priority if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(lpfc_pkg::CAPACITY)) begin
      eff_cap = CW'(lpfc_pkg::CAPACITY);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // input register
  logic          in_vld_r, in_vld_nxt;
  logic [FW-1:0] page_r;
  logic          first_r, last_r;
  logic          in_acc, fire;

  // the pass fires when the result register is free or is being emptied
  assign fire     = in_vld_r && (!out_valid || !out_stall);
  assign in_stall = in_vld_r && !fire;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    priority if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      page_r  <= in_page_number;
      first_r <= in_first_of_run;
      last_r  <= in_last_of_run;
    end
  end

  // frame table lookup and update
  lpfc_pkg::lpfc_res_t res;

  lpfc_frame_table u_frames (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (fire),
    .page    (lpfc_pkg::PAGE_BITS'(page_r)),
    .clear   (first_r),
    .eff_cap (eff_cap),
    .res     (res)
  );

  // fault counter, cleared at run start, saturating
  logic [FW-1:0] fault_r, fault_nxt, fault_base;

  assign fault_base = first_r ? '0 : fault_r;

  always_comb begin
    priority if (res.hit || (fault_base == lpfc_pkg::FAULT_MAX)) begin
      fault_nxt = fault_base;
    end else begin
      fault_nxt = fault_base + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= '0;
    end else if (fire) begin
      fault_r <= fault_nxt;
    end
  end

  // result register
  logic out_vld_r, out_vld_nxt;

  always_comb begin
    priority if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_hit           <= res.hit;
      out_evicted_valid <= res.ev_valid;
      out_evicted_page  <= res.ev_page;
      out_fault_count   <= fault_nxt;
      out_run_done      <= last_r;
    end
  end

  assign out_valid = out_vld_r;

`ifndef NO_ASSERTIONS
  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.hit |-> !res.ev_valid)
    else $error("eviction reported on a hit");

  // a fault always leaves a nonzero count
  a_fault_counts: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !res.hit |=> fault_r != '0)
    else $error("fault count zero after a fault");

  // a hit inside a run leaves the counter alone
  a_hit_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.hit && !first_r |=> fault_r == $past(fault_r))
    else $error("fault count moved on a hit");

  // result register holds a stalled transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fault_count))
    else $error("stalled result changed");
`endif

endmodule
